### sv/jsss_pkg.sv
// ----------------------------------------------------------------------------
// jsss_pkg: shared types and constants of the joint shuttle speed sweep
// Beat formats, opcodes, register indexes and fixed-point factors.
// ----------------------------------------------------------------------------
package jsss_pkg;

  localparam int MAX_JOINTS  = 8;
  localparam int MAX_LEVELS  = 8;
  localparam int POS_W       = 16;
  localparam int JOINT_W     = $clog2(MAX_JOINTS);
  localparam int LEVEL_W     = $clog2(MAX_LEVELS);
  localparam int COUNT_W     = 4;
  localparam int HALF_W      = 15;
  localparam int DWELL_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Q0.12 factors and Q4.12 offset
  localparam int Q_FRAC        = 12;
  localparam int K_MARGIN      = 1229;
  localparam int K_BRAKE_BAND  = 1638;
  localparam int K_BRAKE_SPEED = 819;
  localparam int BRAKE_BASE    = 205;

  // result queue
  localparam int MAX_RESULTS = 3;
  localparam int PUSH_W      = 2;
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_AW       = 2;

  localparam logic signed [POS_W-1:0] POS_MAX_V = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN_V = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_SAMPLE      = 3'd0,
    OP_TICK        = 3'd1,
    OP_LOAD_SPEED  = 3'd2,
    OP_LOAD_LOWER  = 3'd3,
    OP_LOAD_UPPER  = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ABS_MODE    = 3'd0,
    CFG_HALF_RANGE  = 3'd1,
    CFG_EDGE_MARGIN = 3'd2,
    CFG_DWELL       = 3'd3,
    CFG_JOINTS      = 3'd4,
    CFG_SPEEDS      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [2:0]              slot;
    logic signed [POS_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic                    joint_valid;
    logic [2:0]              excited_joint;
    logic signed [POS_W-1:0] velocity_cmd;
    logic                    moving_down;
    logic [2:0]              speed_level;
    logic                    sweep_done;
    logic                    last_of_run;
  } res_t;

  // store write port
  typedef struct packed {
    logic                    pos_we;
    logic                    start_we;
    logic                    lower_we;
    logic                    upper_we;
    logic                    speed_we;
    logic [JOINT_W-1:0]      addr;
    logic signed [POS_W-1:0] data;
  } st_wr_t;

  // store read data, reset values already substituted for position, start pose and speed
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] start;
    logic signed [POS_W-1:0] lower;
    logic signed [POS_W-1:0] upper;
    logic signed [POS_W-1:0] speed;
  } st_rd_t;

  // band pipeline result for the direction update
  typedef struct packed {
    logic                    vld;
    logic signed [POS_W-1:0] q;
    logic signed [POS_W:0]   blo;
    logic signed [POS_W:0]   bhi;
    logic signed [POS_W-1:0] brake;
    logic signed [POS_W-1:0] spd;
  } band_t;

endpackage

### sv/jsss_store.sv
// ----------------------------------------------------------------------------
// jsss_store: per-joint and speed-level memories
// Joint memory holds position, start pose, lower and upper bound lanes;
// speed memory holds the level table. Registered read.
// ----------------------------------------------------------------------------
module jsss_store import jsss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  st_wr_t              wr,
  input  logic                rd_en,
  input  logic [JOINT_W-1:0]  rd_joint,
  input  logic [LEVEL_W-1:0]  rd_level,
  output st_rd_t              rd
);

  localparam int LANES = 4;
  localparam int LANE_POS   = 0;
  localparam int LANE_START = 1;
  localparam int LANE_LOWER = 2;
  localparam int LANE_UPPER = 3;

  logic [LANES*POS_W-1:0]  joint_mem [MAX_JOINTS];
  logic signed [POS_W-1:0] speed_mem [MAX_LEVELS];

  logic [MAX_JOINTS-1:0] pos_vld;
  logic [MAX_JOINTS-1:0] start_vld;
  logic [MAX_LEVELS-1:0] speed_vld;

  logic [LANES*POS_W-1:0]  joint_q;
  logic signed [POS_W-1:0] speed_q;
  logic                    pos_ok;
  logic                    start_ok;
  logic                    speed_ok;
  logic [LEVEL_W-1:0]      level_q;
  logic [LANES-1:0]        lane_we;

  function automatic logic signed [POS_W-1:0] default_speed(input logic [LEVEL_W-1:0] lvl);
    logic signed [POS_W-1:0] s;
    unique case (lvl)
      3'd0:    s = POS_W'(410);
      3'd1:    s = POS_W'(819);
      3'd2:    s = POS_W'(1229);
      3'd3:    s = POS_W'(2048);
      3'd4:    s = POS_W'(3277);
      3'd5:    s = POS_W'(4915);
      default: s = '0;
    endcase
    return s;
  endfunction

  assign lane_we = {wr.upper_we, wr.lower_we, wr.start_we, wr.pos_we};

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (lane_we[l]) begin
        joint_mem[wr.addr][l*POS_W +: POS_W] <= wr.data;
      end
    end
    if (wr.speed_we) begin
      speed_mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      joint_q  <= joint_mem[rd_joint];
      speed_q  <= speed_mem[rd_level];
      pos_ok   <= pos_vld[rd_joint];
      start_ok <= start_vld[rd_joint];
      speed_ok <= speed_vld[rd_level];
      level_q  <= rd_level;
    end
  end

  // position, start pose and speed entries never written read as their reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_vld   <= '0;
      start_vld <= '0;
      speed_vld <= '0;
    end else begin
      if (wr.pos_we)   pos_vld[wr.addr]   <= 1'b1;
      if (wr.start_we) start_vld[wr.addr] <= 1'b1;
      if (wr.speed_we) speed_vld[wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    rd.pos   = pos_ok   ? joint_q[LANE_POS*POS_W +: POS_W]   : '0;
    rd.start = start_ok ? joint_q[LANE_START*POS_W +: POS_W] : '0;
    rd.lower = joint_q[LANE_LOWER*POS_W +: POS_W];
    rd.upper = joint_q[LANE_UPPER*POS_W +: POS_W];
    rd.speed = speed_ok ? speed_q : default_speed(level_q);
  end

endmodule

### sv/jsss_band.sv
// ----------------------------------------------------------------------------
// jsss_band: three-stage band and braking-distance pipeline
// Forms the band, applies the margin, then the braking distance.
// ----------------------------------------------------------------------------
module jsss_band import jsss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_vld,
  input  st_rd_t             rd,
  input  logic               abs_mode,
  input  logic [HALF_W-1:0]  half_range,
  input  logic [HALF_W-1:0]  edge_margin,
  output band_t              band
);

  localparam int WW = POS_W + 2;
  localparam int PW = POS_W + Q_FRAC;
  localparam logic signed [WW-1:0] POS_MAX_W = WW'(POS_MAX_V);
  localparam logic signed [WW-1:0] POS_MIN_W = WW'(POS_MIN_V);
  localparam logic [PW-1:0]        KM  = PW'(K_MARGIN);
  localparam logic [PW-1:0]        KB  = PW'(K_BRAKE_BAND);
  localparam logic signed [PW-1:0] KS  = PW'(K_BRAKE_SPEED);
  localparam logic signed [POS_W-1:0] BASE = POS_W'(BRAKE_BASE);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    if (v > POS_MAX_W) begin
      r = POS_MAX_W;
    end else if (v < POS_MIN_W) begin
      r = POS_MIN_W;
    end else begin
      r = v;
    end
    return r[POS_W-1:0];
  endfunction

  // stage 1: band edges from bounds or start pose
  logic signed [WW-1:0]    st_w;
  logic signed [WW-1:0]    hr_w;
  logic signed [POS_W-1:0] lo_sel, hi_sel, lo_ord, hi_ord;
  logic signed [POS_W:0]   diff_w;

  logic                    s1_vld;
  logic signed [POS_W-1:0] s1_q, s1_lo, s1_hi, s1_spd;
  logic [POS_W-1:0]        s1_diff;

  always_comb begin
    st_w = WW'(rd.start);
    hr_w = WW'({1'b0, half_range});
    if (abs_mode) begin
      lo_sel = rd.lower;
      hi_sel = rd.upper;
    end else begin
      lo_sel = sat_pos(st_w - hr_w);
      hi_sel = sat_pos(st_w + hr_w);
    end
    // swap reversed bounds
    if (hi_sel < lo_sel) begin
      lo_ord = hi_sel;
      hi_ord = lo_sel;
    end else begin
      lo_ord = lo_sel;
      hi_ord = hi_sel;
    end
    diff_w = (POS_W+1)'(hi_ord) - (POS_W+1)'(lo_ord);
  end

  always_ff @(posedge clk) begin
    s1_q    <= rd.pos;
    s1_lo   <= lo_ord;
    s1_hi   <= hi_ord;
    s1_diff <= diff_w[POS_W-1:0];
    s1_spd  <= rd.speed;
  end

  // stage 2: margin and speed term of the braking distance
  logic [PW-1:0]           prod_m;
  logic [POS_W-1:0]        m_raw, m_eff;
  logic signed [PW-1:0]    spd_w, prod_s;
  logic signed [POS_W-1:0] b2_w;

  logic                    s2_vld;
  logic signed [POS_W-1:0] s2_q, s2_b2, s2_spd;
  logic signed [POS_W:0]   s2_blo, s2_bhi;
  logic [POS_W-1:0]        s2_band;

  always_comb begin
    prod_m = PW'(s1_diff) * KM;
    m_raw  = prod_m[PW-1:Q_FRAC];
    m_eff  = (m_raw > POS_W'(edge_margin)) ? POS_W'(edge_margin) : m_raw;
    spd_w  = PW'(s1_spd);
    prod_s = spd_w * KS;
    b2_w   = prod_s[PW-1:Q_FRAC] + BASE;
  end

  always_ff @(posedge clk) begin
    s2_q    <= s1_q;
    s2_blo  <= (POS_W+1)'(s1_lo) + (POS_W+1)'(m_eff);
    s2_bhi  <= (POS_W+1)'(s1_hi) - (POS_W+1)'(m_eff);
    s2_band <= s1_diff - (m_eff << 1);
    s2_b2   <= b2_w;
    s2_spd  <= s1_spd;
  end

  // stage 3: band term of the braking distance, take the smaller
  logic [PW-1:0]           prod_b;
  logic signed [POS_W-1:0] br_w;

  always_comb begin
    prod_b = PW'(s2_band) * KB;
    br_w   = prod_b[PW-1:Q_FRAC];
  end

  always_ff @(posedge clk) begin
    band.q     <= s2_q;
    band.blo   <= s2_blo;
    band.bhi   <= s2_bhi;
    band.brake <= (s2_b2 < br_w) ? s2_b2 : br_w;
    band.spd   <= s2_spd;
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      band.vld <= 1'b0;
    end else begin
      s1_vld   <= rd_vld;
      s2_vld   <= s1_vld;
      band.vld <= s2_vld;
    end
  end

endmodule

### sv/jsss_outq.sv
// ----------------------------------------------------------------------------
// jsss_outq: result queue
// Takes up to three beats per cycle, hands out one beat per cycle while pop is high.
// ----------------------------------------------------------------------------
module jsss_outq import jsss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [PUSH_W-1:0] push_n,
  input  res_t              push_data [MAX_RESULTS],
  input  logic              pop,
  output logic              head_vld,
  output res_t              head,
  output logic [OQ_AW:0]    count
);

  res_t             q_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (PUSH_W'(k) < push_n) begin
        q_mem[wr_ptr + OQ_AW'(k)] <= push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(push_n);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count + (OQ_AW+1)'(push_n) - (OQ_AW+1)'(pop);
    end
  end

  assign head_vld = (count != '0);
  assign head     = q_mem[rd_ptr];

endmodule

### sv/joint_shuttle_speed_sweep.sv
// ----------------------------------------------------------------------------
// joint_shuttle_speed_sweep: excitation sequencer for joint friction tests
// Samples and table loads go to the store; ticks drive one joint back and
// forth inside its band and step through speed levels and joints.
// ----------------------------------------------------------------------------
// Result path: a running tick's results enter the queue after the store read,
//   the three band stages and the update; a tick after the sweep ends queues
//   its single result at once.
// Flow: samples, loads and config writes are never stalled; a tick waits until
//   no earlier tick is in flight and the result queue has three free slots.
// Reset: synchronous; clears sweep state, valid bits and queue, no clear pass.
// ----------------------------------------------------------------------------
module joint_shuttle_speed_sweep import jsss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WT = POS_W + 2;

  // configuration
  logic               abs_bounds_mode;
  logic [HALF_W-1:0]  half_range;
  logic [HALF_W-1:0]  edge_margin;
  logic [DWELL_W-1:0] dwell_ticks;
  logic [COUNT_W-1:0] joint_count;
  logic [COUNT_W-1:0] speed_count;

  // sweep state
  logic               have_sample;
  logic               started;
  logic               finished;
  logic [COUNT_W-1:0] cur_joint;
  logic [LEVEL_W-1:0] cur_level;
  logic               dir_neg;
  logic [DWELL_W-1:0] dwell_cnt;
  logic               tick_busy;
  logic               rd_pending;

  logic               accept;
  logic               is_tick;
  logic               tick_ok;
  logic               run_tick;
  logic               start_tick;
  logic               done_tick;

  st_wr_t             st_wr;
  st_rd_t             st_rd;
  band_t              band;

  logic [PUSH_W-1:0]  push_n;
  res_t               push_data [MAX_RESULTS];
  logic [OQ_AW:0]     q_count;
  logic               pop;

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c,
                                                   input logic [COUNT_W-1:0] maxv);
    logic [COUNT_W-1:0] r;
    if (c == '0) begin
      r = COUNT_W'(1);
    end else if (c > maxv) begin
      r = maxv;
    end else begin
      r = c;
    end
    return r;
  endfunction

  assign cfg_ready  = 1'b1;
  assign is_tick    = (item.opcode == OP_TICK);
  assign tick_ok    = !tick_busy && (q_count <= (OQ_AW+1)'(OQ_DEPTH - MAX_RESULTS));
  assign item_stall = is_tick && !tick_ok;
  assign accept     = item_valid && !item_stall;
  assign run_tick   = accept && is_tick && have_sample && started && !finished;
  assign start_tick = accept && is_tick && have_sample && !started;
  assign done_tick  = accept && is_tick && have_sample && started && finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_bounds_mode <= 1'b0;
      half_range      <= HALF_W'(1843);
      edge_margin     <= HALF_W'(356);
      dwell_ticks     <= DWELL_W'(1000);
      joint_count     <= COUNT_W'(7);
      speed_count     <= COUNT_W'(6);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ABS_MODE:    abs_bounds_mode <= cfg_data[0];
        CFG_HALF_RANGE:  half_range      <= cfg_data[HALF_W-1:0];
        CFG_EDGE_MARGIN: edge_margin     <= cfg_data[HALF_W-1:0];
        CFG_DWELL:       dwell_ticks     <= cfg_data[DWELL_W-1:0];
        CFG_JOINTS:      joint_count     <= cfg_data[COUNT_W-1:0];
        CFG_SPEEDS:      speed_count     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // store writes; before the start, samples also land in the start pose
  always_comb begin
    st_wr.pos_we   = accept && (item.opcode == OP_SAMPLE);
    st_wr.start_we = st_wr.pos_we && !started;
    st_wr.lower_we = accept && (item.opcode == OP_LOAD_LOWER);
    st_wr.upper_we = accept && (item.opcode == OP_LOAD_UPPER);
    st_wr.speed_we = accept && (item.opcode == OP_LOAD_SPEED);
    st_wr.addr     = item.slot;
    st_wr.data     = item.value;
  end

  jsss_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (st_wr),
    .rd_en    (run_tick),
    .rd_joint (cur_joint[JOINT_W-1:0]),
    .rd_level (cur_level),
    .rd       (st_rd)
  );

  jsss_band u_band (
    .clk         (clk),
    .rst         (rst),
    .rd_vld      (rd_pending),
    .rd          (st_rd),
    .abs_mode    (abs_bounds_mode),
    .half_range  (half_range),
    .edge_margin (edge_margin),
    .band        (band)
  );

  // direction update and result beats
  logic [COUNT_W-1:0]      nj, ns;
  logic signed [WT-1:0]    q_w, hi_thr, lo_thr;
  logic                    dir_n;
  logic signed [POS_W-1:0] vel;
  logic                    jv;
  logic [DWELL_W:0]        cnt_inc;
  logic                    adv;
  logic [COUNT_W-1:0]      lvl_inc;
  logic [COUNT_W-1:0]      joint_inc;
  logic                    wrap;
  logic                    done;

  always_comb begin
    nj        = eff_count(joint_count, COUNT_W'(MAX_JOINTS));
    ns        = eff_count(speed_count, COUNT_W'(MAX_LEVELS));
    q_w       = WT'(band.q);
    hi_thr    = WT'(band.bhi) - WT'(band.brake);
    lo_thr    = WT'(band.blo) + WT'(band.brake);
    if (q_w >= hi_thr) begin
      dir_n = 1'b1;
    end else if (q_w <= lo_thr) begin
      dir_n = 1'b0;
    end else begin
      dir_n = dir_neg;
    end
    if (!dir_n) begin
      vel = band.spd;
    end else if (band.spd == POS_MIN_V) begin
      vel = POS_MAX_V;
    end else begin
      vel = -band.spd;
    end
    jv        = (cur_joint < nj);
    cnt_inc   = {1'b0, dwell_cnt} + (DWELL_W+1)'(1);
    adv       = (cnt_inc >= {1'b0, dwell_ticks});
    lvl_inc   = COUNT_W'(cur_level) + COUNT_W'(1);
    joint_inc = cur_joint + COUNT_W'(1);
    wrap      = adv && (lvl_inc >= ns);
    done      = wrap && (joint_inc >= nj);
  end

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      push_data[k] = '0;
    end
    push_n = '0;
    if (band.vld) begin
      push_data[0].joint_valid   = jv;
      push_data[0].excited_joint = jv ? cur_joint[JOINT_W-1:0] : '0;
      push_data[0].velocity_cmd  = jv ? vel : '0;
      push_data[0].moving_down   = dir_n;
      push_data[0].speed_level   = cur_level;
      push_data[0].last_of_run   = !wrap;
      // joint finished: command it to zero
      push_data[1].joint_valid   = jv;
      push_data[1].excited_joint = jv ? cur_joint[JOINT_W-1:0] : '0;
      push_data[1].moving_down   = dir_n;
      push_data[1].last_of_run   = !done;
      push_data[2].moving_down   = dir_n;
      push_data[2].sweep_done    = 1'b1;
      push_data[2].last_of_run   = 1'b1;
      push_n = PUSH_W'(1) + PUSH_W'(wrap) + PUSH_W'(done);
    end else if (done_tick) begin
      push_data[0].moving_down   = dir_neg;
      push_data[0].speed_level   = cur_level;
      push_data[0].sweep_done    = 1'b1;
      push_data[0].last_of_run   = 1'b1;
      push_n = PUSH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_sample <= 1'b0;
      started     <= 1'b0;
      finished    <= 1'b0;
      cur_joint   <= '0;
      cur_level   <= '0;
      dir_neg     <= 1'b0;
      dwell_cnt   <= '0;
      tick_busy   <= 1'b0;
      rd_pending  <= 1'b0;
    end else begin
      rd_pending <= run_tick;
      if (st_wr.pos_we) have_sample <= 1'b1;
      if (start_tick) begin
        started   <= 1'b1;
        cur_joint <= '0;
        cur_level <= '0;
        dir_neg   <= 1'b0;
        dwell_cnt <= '0;
      end
      if (run_tick) tick_busy <= 1'b1;
      if (band.vld) begin
        tick_busy <= 1'b0;
        dir_neg   <= (wrap && !done) ? 1'b0 : dir_n;
        if (adv) begin
          dwell_cnt <= '0;
          cur_level <= wrap ? '0 : lvl_inc[LEVEL_W-1:0];
        end else begin
          dwell_cnt <= cnt_inc[DWELL_W] ? '1 : cnt_inc[DWELL_W-1:0];
        end
        if (wrap) cur_joint <= joint_inc;
        if (done) finished <= 1'b1;
      end
    end
  end

  assign pop = res_valid && !res_stall;

  jsss_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (push_data),
    .pop       (pop),
    .head_vld  (res_valid),
    .head      (res),
    .count     (q_count)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue overflow");

  a_band_in_tick: assert property (@(posedge clk) disable iff (rst)
    band.vld |-> tick_busy)
    else $error("band result without a tick in flight");

  a_tick_holds_busy: assert property (@(posedge clk) disable iff (rst)
    run_tick |=> (tick_busy && !run_tick))
    else $error("tick accepted while another tick is in flight");

  a_finished_sticks: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag dropped");

endmodule
